### hdl/mva_pkg.sv
// shared types and constants for the msi vector allocator
`timescale 1ns / 1ps

package mva_pkg;

    localparam int NUM_VECTORS = 190;
    localparam int VECTOR_BASE = 65;

    // only vectors that fit in 8 bits are handed out
    localparam int POOL_SIZE = (NUM_VECTORS < (256 - VECTOR_BASE)) ?
                               NUM_VECTORS : (256 - VECTOR_BASE);
    localparam int SLOT_W    = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

    // first-fit search: lowest free bit per group, then lowest free group
    localparam int GRP_SIZE  = 32;
    localparam int GRP_IW    = $clog2(GRP_SIZE);
    localparam int NUM_GRP   = (POOL_SIZE + GRP_SIZE - 1) / GRP_SIZE;

    localparam int REF_W     = 64;
    localparam int VEC_W     = 8;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INTR  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_SPURIOUS = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic rd_en;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_sts_t;

endpackage

### hdl/mva_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module mva_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/mva_datapath.sv
// datapath: request registers, slot used bits, first-fit search, reference ram, result register
`timescale 1ns / 1ps

module mva_datapath import mva_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    output dp_sts_t           sts,
    input  logic [1:0]        opcode,
    input  logic [VEC_W-1:0]  vector,
    input  logic [REF_W-1:0]  handler_ref,
    input  logic [REF_W-1:0]  context_ref,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [VEC_W-1:0]  vector_out,
    output logic [REF_W-1:0]  handler_out,
    output logic [REF_W-1:0]  context_out
);

    // request registers
    opcode_t          op_reg;
    logic [VEC_W-1:0] vec_reg;
    logic [REF_W-1:0] hnd_reg;
    logic [REF_W-1:0] ctx_reg;

    // slot state
    logic [POOL_SIZE-1:0] slot_used_reg;
    logic [POOL_SIZE-1:0] slot_used_next;

    // group summary of the search
    logic [NUM_GRP-1:0] grp_free_reg;
    logic [NUM_GRP-1:0] grp_free_next;
    logic [GRP_IW-1:0]  grp_idx_reg  [NUM_GRP];
    logic [GRP_IW-1:0]  grp_idx_next [NUM_GRP];

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [VEC_W-1:0] vector_out_reg;
    logic [VEC_W-1:0] vector_out_next;
    logic [REF_W-1:0] handler_out_reg;
    logic [REF_W-1:0] handler_out_next;
    logic [REF_W-1:0] context_out_reg;
    logic [REF_W-1:0] context_out_next;

    logic              alloc_ok;
    logic [SLOT_W-1:0] alloc_slot;
    logic [VEC_W:0]    vec_off;
    logic              in_range;
    logic [SLOT_W-1:0] vec_slot;
    logic              vec_used;
    logic              ram_wr_en;
    logic [2*REF_W-1:0] ram_rd_data;

    // vector to slot, with range check against the pool
    always_comb
    begin
        vec_off  = {1'b0, vec_reg} - (VEC_W+1)'(VECTOR_BASE);
        in_range = !vec_off[VEC_W] && (vec_off < (VEC_W+1)'(POOL_SIZE));
        vec_slot = vec_off[SLOT_W-1:0];
        vec_used = in_range ? slot_used_reg[vec_slot] : 1'b0;
    end

    // lowest free bit within each group; bits past the pool count as used
    always_comb
    begin
        for (int g = 0; g < NUM_GRP; g++)
        begin
            grp_free_next[g] = 1'b0;
            grp_idx_next[g]  = '0;
            for (int j = GRP_SIZE - 1; j >= 0; j--)
            begin
                if ((g * GRP_SIZE + j) < POOL_SIZE)
                begin
                    if (!slot_used_reg[g * GRP_SIZE + j])
                    begin
                        grp_free_next[g] = 1'b1;
                        grp_idx_next[g]  = GRP_IW'(j);
                    end
                end
            end
        end
    end

    // lowest group with a free slot
    always_comb
    begin
        alloc_ok   = 1'b0;
        alloc_slot = '0;
        for (int g = NUM_GRP - 1; g >= 0; g--)
        begin
            if (grp_free_reg[g])
            begin
                alloc_ok   = 1'b1;
                alloc_slot = SLOT_W'(g * GRP_SIZE + int'(grp_idx_reg[g]));
            end
        end
    end

    always_comb
    begin
        slot_used_next   = slot_used_reg;
        ram_wr_en        = 1'b0;
        status_next      = status_reg;
        vector_out_next  = vector_out_reg;
        handler_out_next = handler_out_reg;
        context_out_next = context_out_reg;
        out_valid_next   = out_stall ? out_valid_reg : 1'b0;

        if (cmd.commit)
        begin
            out_valid_next   = 1'b1;
            status_next      = ST_OK;
            vector_out_next  = '0;
            handler_out_next = '0;
            context_out_next = '0;
            case (op_reg)
                OP_ALLOC:
                begin
                    if (alloc_ok)
                    begin
                        slot_used_next[alloc_slot] = 1'b1;
                        ram_wr_en       = 1'b1;
                        vector_out_next = VEC_W'((VEC_W+1)'(alloc_slot)
                                                 + (VEC_W+1)'(VECTOR_BASE));
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
                OP_FREE:
                begin
                    if (in_range)
                    begin
                        slot_used_next[vec_slot] = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_RANGE;
                    end
                end
                OP_INTR:
                begin
                    if (!in_range)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (vec_used)
                    begin
                        handler_out_next = ram_rd_data[2*REF_W-1:REF_W];
                        context_out_next = ram_rd_data[REF_W-1:0];
                    end
                    else
                    begin
                        status_next = ST_SPURIOUS;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_used_reg <= slot_used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= opcode_t'(opcode);
            vec_reg <= vector;
            hnd_reg <= handler_ref;
            ctx_reg <= context_ref;
        end
        grp_free_reg    <= grp_free_next;
        grp_idx_reg     <= grp_idx_next;
        status_reg      <= status_next;
        vector_out_reg  <= vector_out_next;
        handler_out_reg <= handler_out_next;
        context_out_reg <= context_out_next;
    end

    // handler in the upper half, context in the lower half
    mva_ram #(
        .WIDTH (2 * REF_W),
        .DEPTH (POOL_SIZE),
        .ADDR_W(SLOT_W)
    ) u_ref_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(alloc_slot),
        .wr_data({hnd_reg, ctx_reg}),
        .rd_en  (cmd.rd_en && in_range),
        .rd_addr(vec_slot),
        .rd_data(ram_rd_data)
    );

    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign vector_out  = vector_out_reg;
    assign handler_out = handler_out_reg;
    assign context_out = context_out_reg;

endmodule

### hdl/mva_ctrl.sv
// controller: sequences accept, lookup and commit of one request
`timescale 1ns / 1ps

module mva_ctrl import mva_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the result register can take the new result
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign cmd.latch_in = (state_reg == S_IDLE) && in_valid;
    assign cmd.rd_en    = (state_reg == S_EXEC);
    assign cmd.commit   = (state_reg == S_FIN) && sts.out_free;

endmodule

### hdl/msi_vector_allocator.sv
// top level of the msi vector allocator
//
//  channel  handshake            payload
//  in       in_valid / in_stall  opcode, vector, handler_ref, context_ref
//  out      out_valid / out_stall status, vector_out, handler_out, context_out
//
// each request passes through accept, lookup (search summary and ram read) and
// commit, one at a time; lookup is its own state since search and ram read are registered
// one result register sits on the output; a waiting result does not block the next accept
// commit waits while the result register is full and stalled
// reset clears all slot used marks at once; no clearing pass is needed
`timescale 1ns / 1ps

module msi_vector_allocator import mva_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [VEC_W-1:0]  vector,
    input  logic [REF_W-1:0]  handler_ref,
    input  logic [REF_W-1:0]  context_ref,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [1:0]        status,
    output logic [VEC_W-1:0]  vector_out,
    output logic [REF_W-1:0]  handler_out,
    output logic [REF_W-1:0]  context_out
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    mva_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd     (cmd),
        .sts     (sts)
    );

    mva_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .opcode     (opcode),
        .vector     (vector),
        .handler_ref(handler_ref),
        .context_ref(context_ref),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .vector_out (vector_out),
        .handler_out(handler_out),
        .context_out(context_out)
    );

endmodule
